// File: rtl/fab_pkg.sv
// ----------------------------------------------------------------------------
// fab_pkg
// Shared constants, types and helpers of the face anchor box decoder.
// ----------------------------------------------------------------------------
package fab_pkg;

    localparam int MAX_IMAGE_SIZE  = 4096;
    localparam int KEYPOINT_COUNT  = 5;
    localparam int FRAC_BITS       = 12;
    localparam int LANDMARK_FIELDS = 5;
    localparam int KP_EMIT         = (KEYPOINT_COUNT < LANDMARK_FIELDS) ?
                                     KEYPOINT_COUNT : LANDMARK_FIELDS;
    localparam int FAB_QUEUE_DEPTH = 4;
    localparam int LEVEL_COUNT     = 3;

    localparam int VAR_CENTER_Q16  = 6554;
    localparam int VAR_SIZE_Q16    = 13107;
    localparam int LN2_Q16         = 45426;
    localparam int LN2_RECIP_Q32   = 94548;
    localparam int EXP_ARG_LIMIT   = 786432;

    localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd1000;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1000;
    localparam logic [15:0] RST_THRESHOLD    = 16'd32768;

    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd2;

    localparam logic KIND_FACE     = 1'b0;
    localparam logic KIND_KEYPOINT = 1'b1;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [15:0] score_threshold;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0]                  delta_cx;
        logic signed [15:0]                  delta_cy;
        logic signed [15:0]                  delta_w;
        logic signed [15:0]                  delta_h;
        logic [15:0]                         face_score;
        logic [LANDMARK_FIELDS-1:0][31:0]    landmark;
        logic [1:0]                          level;
        logic                                size_select;
        logic [9:0]                          column;
        logic [9:0]                          row;
        logic [19:0]                         anchor_number;
    } t_entry;

    typedef struct packed {
        logic               start;
        logic signed [15:0] delta;
        logic [3:0]         size_exp;
    } t_exp_req;

    typedef struct packed {
        logic        done;
        logic [32:0] size;
    } t_exp_rsp;

    function automatic logic signed [17:0] sat18(input logic signed [47:0] v);
        if (v > 48'sd131071) begin
            return 18'sh1FFFF;
        end else if (v < -48'sd131072) begin
            return 18'sh20000;
        end
        return v[17:0];
    endfunction

    // log2 of the prior size in pixels
    function automatic logic [3:0] size_exp(input logic [1:0] level, input logic sel);
        return 4'd4 + {1'b0, level, 1'b0} + {3'd0, sel};
    endfunction

endpackage

// File: rtl/fab_if.sv
// ----------------------------------------------------------------------------
// fab_in_if / fab_out_if
// Valid/ready channels carrying anchor predictions in and decoded boxes out.
// ----------------------------------------------------------------------------
interface fab_in_if;
    logic               valid;
    logic               ready;
    logic               first_of_image;
    logic signed [15:0] delta_cx;
    logic signed [15:0] delta_cy;
    logic signed [15:0] delta_w;
    logic signed [15:0] delta_h;
    logic [15:0]        face_score;
    logic [31:0]        landmark_one;
    logic [31:0]        landmark_two;
    logic [31:0]        landmark_three;
    logic [31:0]        landmark_four;
    logic [31:0]        landmark_five;

    modport source (
        output valid, first_of_image, delta_cx, delta_cy, delta_w, delta_h,
               face_score, landmark_one, landmark_two, landmark_three,
               landmark_four, landmark_five,
        input  ready
    );
    modport sink (
        input  valid, first_of_image, delta_cx, delta_cy, delta_w, delta_h,
               face_score, landmark_one, landmark_two, landmark_three,
               landmark_four, landmark_five,
        output ready
    );
endinterface

interface fab_out_if;
    logic               valid;
    logic               ready;
    logic               item_kind;
    logic signed [17:0] left_x;
    logic signed [17:0] top_y;
    logic signed [17:0] right_x;
    logic signed [17:0] bottom_y;
    logic [19:0]        anchor_number;
    logic [15:0]        score_out;
    logic               last_of_run;

    modport source (
        output valid, item_kind, left_x, top_y, right_x, bottom_y,
               anchor_number, score_out, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, item_kind, left_x, top_y, right_x, bottom_y,
               anchor_number, score_out, last_of_run,
        output ready
    );
endinterface

// File: rtl/fab_fifo.sv
// ----------------------------------------------------------------------------
// fab_fifo
// Short request queue between the anchor walker and the box decoder.
// ----------------------------------------------------------------------------
module fab_fifo import fab_pkg::*; #(
    parameter int DEPTH = FAB_QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    input  logic   i_pop,
    output t_entry o_data,
    output logic   o_full,
    output logic   o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_entry                r_mem [DEPTH];
    logic [PW-1:0]         r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]         r_rd_ptr, n_rd_ptr;
    logic [$clog2(DEPTH+1)-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == ($clog2(DEPTH+1))'(DEPTH));
    assign o_empty = (r_count == '0);
endmodule

// File: rtl/fab_exp.sv
// ----------------------------------------------------------------------------
// fab_exp
// Iterative box size unit: s * exp(0.2 * d) in Q4 via range reduction and a
// series summed through its 14th-order term.
// ----------------------------------------------------------------------------
module fab_exp import fab_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_exp_req i_req,
    output t_exp_rsp o_rsp
);
    typedef enum logic [2:0] {
        E_IDLE, E_DIV, E_REM, E_MUL, E_DIVN, E_SCALE, E_FIN, E_OUT
    } t_state;

    t_state             r_state;
    logic [3:0]         r_e;
    logic [19:0]        r_a_abs;
    logic               r_a_neg;
    logic [4:0]         r_q;
    logic signed [5:0]  r_k;
    logic signed [16:0] r_r;
    logic signed [31:0] r_term;
    logic signed [48:0] r_prod;
    logic signed [32:0] r_sum;
    logic [3:0]         r_n;
    logic [48:0]        r_big;
    logic [32:0]        r_size;

    // exact floor(x / n) for x below 2^31 as (x * m) >> s
    function automatic logic [31:0] recip_m(input logic [3:0] n);
        case (n)
            4'd3, 4'd6, 4'd12: return 32'd2863311531;
            4'd5, 4'd10:       return 32'd3435973837;
            4'd7, 4'd14:       return 32'd2454267027;
            4'd9:              return 32'd3817748708;
            4'd11:             return 32'd3123612579;
            4'd13:             return 32'd2643056798;
            default:           return 32'd2147483648;
        endcase
    endfunction

    function automatic logic [5:0] recip_s(input logic [3:0] n);
        case (n)
            4'd1:                                    return 6'd31;
            4'd2:                                    return 6'd32;
            4'd3, 4'd4:                              return 6'd33;
            4'd5, 4'd6, 4'd7, 4'd8:                  return 6'd34;
            default:                                 return 6'd35;
        endcase
    endfunction

    logic signed [31:0] a_prod;
    logic signed [31:0] a_rnd;
    logic [19:0]        a_abs;
    logic [36:0]        q_prod;
    logic [20:0]        rem0;
    logic [20:0]        rem;
    logic [4:0]         q_fix;
    logic signed [48:0] x_full;
    logic signed [32:0] x;
    logic [30:0]        ax;
    logic [62:0]        dq_prod;
    logic [30:0]        dq;
    logic signed [31:0] t_next;
    logic               start_ok;

    always_comb begin
        a_prod = i_req.delta * 32'(VAR_SIZE_Q16);
        a_rnd  = (a_prod + (32'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (a_rnd > 32'(EXP_ARG_LIMIT)) begin
            a_abs = 20'(EXP_ARG_LIMIT);
        end else if (a_rnd < -32'(EXP_ARG_LIMIT)) begin
            a_abs = 20'(EXP_ARG_LIMIT);
        end else if (a_rnd < 0) begin
            a_abs = 20'(-a_rnd);
        end else begin
            a_abs = 20'(a_rnd);
        end

        q_prod = {17'd0, r_a_abs} * 37'(LN2_RECIP_Q32);
        rem0   = {1'b0, r_a_abs} - 21'({16'd0, r_q} * 21'(LN2_Q16));
        rem    = rem0;
        q_fix  = r_q;
        if (rem0 >= 21'(LN2_Q16)) begin
            rem   = rem0 - 21'(LN2_Q16);
            q_fix = r_q + 1'b1;
        end

        x_full  = (r_prod + 49'sd32768) >>> 16;
        x       = x_full[32:0];
        ax      = (x < 0) ? 31'(-x) : 31'(x);
        dq_prod = {32'd0, ax} * {31'd0, recip_m(r_n)};
        dq      = 31'(dq_prod >> recip_s(r_n));
        t_next  = (x < 0) ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
        start_ok = (r_state == E_IDLE) || (r_state == E_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            case (r_state)
                E_IDLE, E_OUT: begin
                    if (start_ok && i_req.start) begin
                        r_state <= E_DIV;
                    end else begin
                        r_state <= E_IDLE;
                    end
                end
                E_DIV:   r_state <= E_REM;
                E_REM:   r_state <= E_MUL;
                E_MUL:   r_state <= E_DIVN;
                E_DIVN:  r_state <= (r_n == 4'd14) ? E_SCALE : E_MUL;
                E_SCALE: r_state <= E_FIN;
                E_FIN:   r_state <= E_OUT;
                default: r_state <= E_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE, E_OUT: begin
                r_e     <= i_req.size_exp;
                r_a_abs <= a_abs;
                r_a_neg <= (a_rnd < 0);
            end
            E_DIV: begin
                r_q <= 5'(q_prod >> 32);
            end
            E_REM: begin
                r_k    <= r_a_neg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
                r_r    <= r_a_neg ? -$signed({1'b0, rem[15:0]}) : $signed({1'b0, rem[15:0]});
                r_term <= 32'sd1 <<< 30;
                r_sum  <= 33'sd1 <<< 30;
                r_n    <= 4'd1;
            end
            E_MUL: begin
                r_prod <= r_term * r_r;
            end
            E_DIVN: begin
                r_term <= t_next;
                r_sum  <= r_sum + 33'(t_next);
                r_n    <= r_n + 1'b1;
            end
            E_SCALE: begin
                if (r_k >= 0) begin
                    r_big <= {16'd0, r_sum} << r_k;
                end else begin
                    r_big <= {16'd0, r_sum} >> (-r_k);
                end
            end
            E_FIN: begin
                r_size <= 33'((r_big + (49'd1 << (5'd25 - {1'b0, r_e})))
                              >> (5'd26 - {1'b0, r_e}));
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done = (r_state == E_OUT);
    assign o_rsp.size = r_size;
endmodule

// File: rtl/fab_front.sv
// ----------------------------------------------------------------------------
// fab_front
// Anchor grid walker: takes one prediction a cycle while the queue has room,
// tags it with its prior and queues in-grid ones that pass the threshold.
// ----------------------------------------------------------------------------
module fab_front import fab_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    fab_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_entry o_entry
);
    logic [1:0]  r_level, n_level;
    logic [9:0]  r_row, n_row;
    logic [9:0]  r_col, n_col;
    logic        r_sel, n_sel;
    logic [19:0] r_anchor, n_anchor;

    logic [1:0]  lv;
    logic [9:0]  row, col;
    logic        sel;
    logic [19:0] anum;
    logic [12:0] w_eff, h_eff;
    logic [13:0] step_m1;
    logic [10:0] cols, rows;
    logic [10:0] col_inc, row_inc;
    logic        in_grid;
    logic        accept;

    always_comb begin
        accept = i_in.valid && i_in.ready;
        lv   = i_in.first_of_image ? '0 : r_level;
        row  = i_in.first_of_image ? '0 : r_row;
        col  = i_in.first_of_image ? '0 : r_col;
        sel  = i_in.first_of_image ? '0 : r_sel;
        anum = i_in.first_of_image ? '0 : r_anchor;

        w_eff = (i_cfg.frame_width  > 13'(MAX_IMAGE_SIZE)) ? 13'(MAX_IMAGE_SIZE)
                                                            : i_cfg.frame_width;
        h_eff = (i_cfg.frame_height > 13'(MAX_IMAGE_SIZE)) ? 13'(MAX_IMAGE_SIZE)
                                                            : i_cfg.frame_height;
        step_m1 = (14'd8 << lv) - 14'd1;
        cols    = 11'(({1'b0, w_eff} + step_m1) >> (3'd3 + {1'b0, lv}));
        rows    = 11'(({1'b0, h_eff} + step_m1) >> (3'd3 + {1'b0, lv}));
        in_grid = (lv < 2'(LEVEL_COUNT)) && (w_eff != '0) && (h_eff != '0);

        n_level  = lv;
        n_row    = row;
        n_col    = col;
        n_sel    = sel;
        n_anchor = anum;
        col_inc  = {1'b0, col} + 11'd1;
        row_inc  = {1'b0, row} + 11'd1;
        if (in_grid) begin
            n_anchor = anum + 20'd1;
            n_sel    = ~sel;
            if (sel) begin
                n_col = col_inc[9:0];
                if (col_inc >= cols) begin
                    n_col = '0;
                    n_row = row_inc[9:0];
                    if (row_inc >= rows) begin
                        n_row   = '0;
                        n_level = lv + 2'd1;
                    end
                end
            end
        end

        o_push = accept && in_grid && (i_in.face_score > i_cfg.score_threshold);
        o_entry.delta_cx      = i_in.delta_cx;
        o_entry.delta_cy      = i_in.delta_cy;
        o_entry.delta_w       = i_in.delta_w;
        o_entry.delta_h       = i_in.delta_h;
        o_entry.face_score    = i_in.face_score;
        o_entry.landmark[0]   = i_in.landmark_one;
        o_entry.landmark[1]   = i_in.landmark_two;
        o_entry.landmark[2]   = i_in.landmark_three;
        o_entry.landmark[3]   = i_in.landmark_four;
        o_entry.landmark[4]   = i_in.landmark_five;
        o_entry.level         = lv;
        o_entry.size_select   = sel;
        o_entry.column        = col;
        o_entry.row           = row;
        o_entry.anchor_number = anum;
    end

    assign i_in.ready = !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_sel    <= '0;
            r_anchor <= '0;
        end else if (accept) begin
            r_level  <= n_level;
            r_row    <= n_row;
            r_col    <= n_col;
            r_sel    <= n_sel;
            r_anchor <= n_anchor;
        end
    end
endmodule

// File: rtl/fab_back.sv
// ----------------------------------------------------------------------------
// fab_back
// Box decoder: pops one passing anchor, sizes the face box, then emits the
// face box and the keypoint boxes through an output register.
// ----------------------------------------------------------------------------
module fab_back import fab_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_entry    i_head,
    output logic      o_pop,
    fab_out_if.source o_out
);
    typedef enum logic [2:0] {B_IDLE, B_EXPW, B_EXPH, B_FACE, B_KP} t_state;

    t_state             r_state;
    t_entry             r_ent;
    logic [32:0]        r_bw;
    logic [32:0]        r_bh;
    logic [2:0]         r_kp;
    logic               r_valid;
    logic               r_kind;
    logic signed [17:0] r_left, r_top, r_right, r_bottom;
    logic [19:0]        r_anum;
    logic [15:0]        r_score;
    logic               r_last;

    t_exp_req req;
    t_exp_rsp rsp;

    fab_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    function automatic logic signed [19:0] center_off(input logic signed [15:0] d,
                                                      input logic [3:0] e);
        logic signed [31:0] p;
        logic signed [47:0] v;
        p = d * 32'(VAR_CENTER_Q16);
        v = ((48'(p)) <<< e) + (48'sd1 <<< (FRAC_BITS + 11));
        return 20'(v >>> (FRAC_BITS + 12));
    endfunction

    logic [3:0]         e;
    logic signed [47:0] cx, cy, ox, oy, bw, bh, left, top, px, py;
    logic [31:0]        lm;
    logic               slot_free;
    logic               emit;

    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_empty;
        req.start = o_pop || ((r_state == B_EXPW) && rsp.done);
        req.delta = o_pop ? i_head.delta_w : r_ent.delta_h;
        req.size_exp = o_pop ? size_exp(i_head.level, i_head.size_select)
                             : size_exp(r_ent.level, r_ent.size_select);

        e  = size_exp(r_ent.level, r_ent.size_select);
        // prior centre in Q4: (2*i+1) * step * 8
        cx = 48'({r_ent.column, 1'b1}) <<< (4'd6 + {2'b0, r_ent.level});
        cy = 48'({r_ent.row, 1'b1}) <<< (4'd6 + {2'b0, r_ent.level});
        ox = cx + 48'(center_off(r_ent.delta_cx, e));
        oy = cy + 48'(center_off(r_ent.delta_cy, e));
        bw = $signed({15'd0, r_bw});
        bh = $signed({15'd0, r_bh});
        left = (2 * ox - bw + 48'sd1) >>> 1;
        top  = (2 * oy - bh + 48'sd1) >>> 1;
        lm = r_ent.landmark[r_kp];
        px = cx + 48'(center_off(lm[15:0], e));
        py = cy + 48'(center_off(lm[31:16], e));
        slot_free = !r_valid || o_out.ready;
        emit = slot_free && ((r_state == B_FACE) || (r_state == B_KP));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_ent   <= i_head;
                        r_state <= B_EXPW;
                    end
                end
                B_EXPW: begin
                    if (rsp.done) begin
                        r_bw    <= rsp.size;
                        r_state <= B_EXPH;
                    end
                end
                B_EXPH: begin
                    if (rsp.done) begin
                        r_bh    <= rsp.size;
                        r_state <= B_FACE;
                    end
                end
                B_FACE: begin
                    if (slot_free) begin
                        r_kind   <= KIND_FACE;
                        r_left   <= sat18(left);
                        r_top    <= sat18(top);
                        r_right  <= sat18(left + bw);
                        r_bottom <= sat18(top + bh);
                        r_anum   <= r_ent.anchor_number;
                        r_score  <= r_ent.face_score;
                        r_last   <= 1'b0;
                        r_kp     <= '0;
                        r_state  <= B_KP;
                    end
                end
                B_KP: begin
                    if (slot_free) begin
                        r_kind   <= KIND_KEYPOINT;
                        r_left   <= sat18(px - 48'sd16);
                        r_top    <= sat18(py - 48'sd16);
                        r_right  <= sat18(px + 48'sd16);
                        r_bottom <= sat18(py + 48'sd16);
                        r_anum   <= r_ent.anchor_number;
                        r_score  <= '0;
                        r_last   <= (r_kp == 3'(KP_EMIT - 1));
                        r_kp     <= r_kp + 1'b1;
                        if (r_kp == 3'(KP_EMIT - 1)) begin
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.item_kind     = r_kind;
    assign o_out.left_x        = r_left;
    assign o_out.top_y         = r_top;
    assign o_out.right_x       = r_right;
    assign o_out.bottom_y      = r_bottom;
    assign o_out.anchor_number = r_anum;
    assign o_out.score_out     = r_score;
    assign o_out.last_of_run   = r_last;
endmodule

// File: rtl/face_anchor_box_decoder.sv
// ----------------------------------------------------------------------------
// face_anchor_box_decoder
// Decodes anchor predictions into face and keypoint boxes in Q13.4 pixels.
// ----------------------------------------------------------------------------
// Input channel i_in: one anchor's deltas, score and packed landmarks per
// request, in grid order; first_of_image restarts the walk. The walker takes
// a request every cycle while the request queue has room.
// Output channel o_out: for each anchor whose score beats the threshold, a
// face box followed by KP_EMIT keypoint boxes, the last flagged last_of_run.
// Anchors that fail, or fall past the grid, produce nothing.
// Decoder flow: the decoder works on one passing anchor at a time. It pops
// the anchor, runs the iterative exp unit twice (width then height), then
// emits the face box and the keypoint boxes in turn through the output
// register as it frees up. Failing anchors are dropped in the walker and
// never reach the queue. A queue of FAB_QUEUE_DEPTH passing anchors sits
// between walker and decoder.
// Reset clears the walk counters, the queue and the output valid flag;
// the registers return to width 1000, height 1000, threshold 0.5.
// A stalled receiver holds the output register, then the decoder, then the
// queue fills and i_in.ready drops.
// ----------------------------------------------------------------------------
module face_anchor_box_decoder import fab_pkg::*; #(
    parameter int QUEUE_DEPTH = FAB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fab_in_if.sink      i_in,
    fab_out_if.source   o_out
);
    t_cfg   r_cfg;
    logic   push, pop, full, empty;
    t_entry entry, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= RST_IMAGE_WIDTH;
            r_cfg.frame_height    <= RST_IMAGE_HEIGHT;
            r_cfg.score_threshold <= RST_THRESHOLD;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:     r_cfg.frame_width     <= pwdata[12:0];
                REG_IMAGE_HEIGHT:    r_cfg.frame_height    <= pwdata[12:0];
                REG_SCORE_THRESHOLD: r_cfg.score_threshold <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:     prdata = {19'd0, r_cfg.frame_width};
            REG_IMAGE_HEIGHT:    prdata = {19'd0, r_cfg.frame_height};
            REG_SCORE_THRESHOLD: prdata = {16'd0, r_cfg.score_threshold};
            default:             prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    fab_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    fab_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry),
        .i_pop   (pop),
        .o_data  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    fab_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && empty))
        else $error("request queue underflow");

    a_last_is_kp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_of_run) |-> (o_out.item_kind == KIND_KEYPOINT))
        else $error("run ends on a face box");

    a_kp_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.item_kind == KIND_KEYPOINT) |-> (o_out.score_out == '0))
        else $error("keypoint box carries a score");
endmodule
